>>> rtl/qfi_pkg.sv
// ----------------------------------------------------------------------------
// qfi_pkg
// Shared types, widths and codes for the quotient filter index.
// ----------------------------------------------------------------------------
package qfi_pkg;

  localparam int SLOT_BITS_DEF = 6;
  localparam int TAG_BITS_DEF  = 32;
  localparam int HIT_BITS_DEF  = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int KEY_W    = 32;
  localparam int ETAG_W   = 32;
  localparam int EHIT_W   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_FLUSHED  = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_RSVD     = 3'd7
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot_index;
    logic [KEY_W-1:0]  key_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ETAG_W-1:0]   entry_tag;
    logic [EHIT_W-1:0]   entry_hits;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // issue read of slot ptr
    S_WAIT,    // read data registered
    S_BACK,    // walk back while shifted
    S_RUNS,    // advance s over a run
    S_OCCS,    // advance b to next occupied
    S_SCAN,    // compare tags in run
    S_SHIFT,   // shift entries right
    S_FLUSH,   // emit valid slots
    S_CLEAR,   // clear table
    S_OUT      // unused by the sequencer
  } state_t;

endpackage

>>> rtl/qfi_ram.sv
// ----------------------------------------------------------------------------
// qfi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module qfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write first is not needed: read returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/quotient_filter_index.sv
// ----------------------------------------------------------------------------
// quotient_filter_index
// Quotient filter table with run search, sorted insert, hit counting and flush.
// ----------------------------------------------------------------------------
//   channel  direction  handshake        payload
//   in       input      in_valid/ready   qfi_pkg::in_item_t
//   out      output     out_valid/ready  qfi_pkg::out_item_t
//
// One slot is read or written per cycle through a single RAM port; each slot
// visited passes through an address step, a registered data step and a
// decision step. Insert and find visit slots walking back to the cluster
// start, over runs, through the run and, for insert, through the shift; a
// full insert or a find on an empty table answers on the next cycle.
// Flush reads each slot up to the last valid one, then clears all
// 2^SLOT_BITS slots; the same clearing pass runs after reset before in_ready.
// The block is busy for one item at a time; a stalled result holds it.
// ----------------------------------------------------------------------------
module quotient_filter_index #(
  parameter int SLOT_BITS = qfi_pkg::SLOT_BITS_DEF,
  parameter int TAG_BITS  = qfi_pkg::TAG_BITS_DEF,
  parameter int HIT_BITS  = qfi_pkg::HIT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qfi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qfi_pkg::out_item_t out_data
);

  localparam int NSLOTS = 1 << SLOT_BITS;
  localparam int CNT_W  = SLOT_BITS + 1;
  localparam int ENT_W  = TAG_BITS + HIT_BITS + 4;
  localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

  // slot layout: {tag, hits, valid, occ, cont, shf}
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [HIT_BITS-1:0] hits;
    logic                valid;
    logic                occ;
    logic                cont;
    logic                shf;
  } slot_t;

  qfi_pkg::state_t state, state_next, ret, ret_next;

  logic [SLOT_BITS-1:0] ptr, ptr_next;     // ram address
  logic [SLOT_BITS-1:0] q, q_next;         // canonical slot
  logic [SLOT_BITS-1:0] s, s_next;         // run start / cursor
  logic [SLOT_BITS-1:0] b, b_next;         // bucket cursor
  logic [SLOT_BITS-1:0] start, start_next;
  logic [CNT_W-1:0]     g, g_next;         // walk guard
  logic [CNT_W-1:0]     cnt, cnt_next;     // entry count
  logic [TAG_BITS-1:0]  tag, tag_next;
  logic [1:0]           cmd, cmd_next;
  logic                 was_occ, was_occ_next;
  logic                 found, found_next; // flush emitted any
  slot_t                cur, cur_next;     // entry being carried in shift
  slot_t                rd;
  logic                 we;
  slot_t                wdata;
  logic [ENT_W-1:0]     rdata_raw;
  qfi_pkg::out_item_t   obuf, obuf_next;
  logic                 ovalid, ovalid_next;
  logic                 clr_done, clr_done_next;

  assign rd = slot_t'(rdata_raw);

  qfi_ram #(.WIDTH(ENT_W), .DEPTH(NSLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (ptr),
    .wdata(ENT_W'(wdata)),
    .rdata(rdata_raw)
  );

  assign in_ready  = (state == qfi_pkg::S_IDLE) && clr_done && !ovalid;
  assign out_valid = ovalid;
  assign out_data  = obuf;

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= qfi_pkg::S_CLEAR;
      ovalid   <= 1'b0;
      cnt      <= '0;
      ptr      <= '0;
      clr_done <= 1'b0;
    end else begin
      state    <= state_next;
      ovalid   <= ovalid_next;
      cnt      <= cnt_next;
      ptr      <= ptr_next;
      clr_done <= clr_done_next;
    end
    ret     <= ret_next;
    q       <= q_next;
    s       <= s_next;
    b       <= b_next;
    start   <= start_next;
    g       <= g_next;
    tag     <= tag_next;
    cmd     <= cmd_next;
    was_occ <= was_occ_next;
    found   <= found_next;
    cur     <= cur_next;
    obuf    <= obuf_next;
  end

  function automatic qfi_pkg::out_item_t mk(qfi_pkg::status_t st);
    qfi_pkg::out_item_t o;
    o.status     = st;
    o.entry_tag  = '0;
    o.entry_hits = '0;
    o.last       = 1'b1;
    return o;
  endfunction

  // sequencer: next state and datapath
  always_comb begin
    slot_t tmp;
    slot_t ne;
    state_next    = state;
    ret_next      = ret;
    ptr_next      = ptr;
    q_next        = q;
    s_next        = s;
    b_next        = b;
    start_next    = start;
    g_next        = g;
    cnt_next      = cnt;
    tag_next      = tag;
    cmd_next      = cmd;
    was_occ_next  = was_occ;
    found_next    = found;
    cur_next      = cur;
    obuf_next     = obuf;
    clr_done_next = clr_done;
    ovalid_next   = ovalid && !out_ready;
    we            = 1'b0;
    wdata         = rd;
    tmp           = rd;
    ne            = '0;
    ne.tag        = tag;
    ne.valid      = 1'b1;

    case (state)
      qfi_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          q_next   = SLOT_BITS'(in_data.slot_index);
          tag_next = TAG_BITS'(in_data.key_tag);
          cmd_next = in_data.command;
          ptr_next = SLOT_BITS'(in_data.slot_index);
          g_next   = '0;
          case (qfi_pkg::cmd_t'(in_data.command))
            qfi_pkg::CMD_INSERT: begin
              if (cnt[SLOT_BITS]) begin
                obuf_next   = mk(qfi_pkg::ST_FULL);
                ovalid_next = 1'b1;
              end else begin
                ret_next   = qfi_pkg::S_BACK;
                state_next = qfi_pkg::S_WAIT;
              end
            end
            qfi_pkg::CMD_FIND: begin
              if (cnt == '0) begin
                obuf_next   = mk(qfi_pkg::ST_MISS);
                ovalid_next = 1'b1;
              end else begin
                ret_next   = qfi_pkg::S_BACK;
                state_next = qfi_pkg::S_WAIT;
              end
            end
            qfi_pkg::CMD_FLUSH: begin
              ptr_next   = '0;
              found_next = 1'b0;
              s_next     = '0;
              ret_next   = qfi_pkg::S_FLUSH;
              state_next = qfi_pkg::S_WAIT;
            end
            default: ;
          endcase
        end
      end

      // ram read latency, data valid next cycle
      qfi_pkg::S_WAIT: begin
        state_next = ret;
      end

      qfi_pkg::S_RD: begin
        state_next = qfi_pkg::S_WAIT;
      end

      // first visit to q handles the simple cases, then walks back
      qfi_pkg::S_BACK: begin
        if (g == '0 && ptr == q) begin
          if (cmd == qfi_pkg::CMD_FIND && !rd.occ) begin
            obuf_next   = mk(qfi_pkg::ST_MISS);
            ovalid_next = 1'b1;
            state_next  = qfi_pkg::S_IDLE;
          end else if (cmd == qfi_pkg::CMD_INSERT && !rd.valid) begin
            ne.occ      = 1'b1;
            we          = 1'b1;
            wdata       = ne;
            cnt_next    = cnt + 1'b1;
            obuf_next   = mk(qfi_pkg::ST_INSERTED);
            ovalid_next = 1'b1;
            state_next  = qfi_pkg::S_IDLE;
          end else begin
            if (cmd == qfi_pkg::CMD_INSERT) begin
              was_occ_next = rd.occ;
              tmp          = rd;
              tmp.occ      = 1'b1;
              we           = 1'b1;
              wdata        = tmp;
            end
            g_next = CNT_W'(1);
            if (rd.shf) begin
              ptr_next   = ptr - 1'b1;
              state_next = qfi_pkg::S_RD;
            end else begin
              b_next     = ptr;
              s_next     = ptr;
              g_next     = '0;
              state_next = qfi_pkg::S_OCCS;
              if (ptr == q) begin
                ptr_next   = ptr;
                state_next = qfi_pkg::S_RD;
                ret_next   = qfi_pkg::S_SCAN;
                start_next = ptr;
                s_next     = ptr;
              end else begin
                ptr_next = ptr + 1'b1;
                ret_next = qfi_pkg::S_RUNS;
                state_next = qfi_pkg::S_RD;
              end
            end
          end
        end else begin
          g_next = g + 1'b1;
          if (rd.shf && g < CNT_W'(NSLOTS)) begin
            ptr_next   = ptr - 1'b1;
            state_next = qfi_pkg::S_RD;
          end else begin
            b_next = ptr;
            s_next = ptr;
            g_next = '0;
            if (ptr == q) begin
              start_next = ptr;
              ret_next   = qfi_pkg::S_SCAN;
              state_next = qfi_pkg::S_RD;
            end else begin
              ptr_next   = ptr + 1'b1;
              ret_next   = qfi_pkg::S_RUNS;
              state_next = qfi_pkg::S_RD;
            end
          end
        end
      end

      // s advances over continuation slots (rd is slot ptr = s+1 ...)
      qfi_pkg::S_RUNS: begin
        s_next = ptr;
        if (rd.cont && g < CNT_W'(NSLOTS - 1)) begin
          g_next     = g + 1'b1;
          ptr_next   = ptr + 1'b1;
          state_next = qfi_pkg::S_RD;
        end else begin
          g_next     = '0;
          ptr_next   = b + 1'b1;
          ret_next   = qfi_pkg::S_OCCS;
          state_next = qfi_pkg::S_RD;
        end
      end

      // b advances to next occupied slot
      qfi_pkg::S_OCCS: begin
        b_next = ptr;
        if (!rd.occ && g < CNT_W'(NSLOTS - 1)) begin
          g_next     = g + 1'b1;
          ptr_next   = ptr + 1'b1;
          state_next = qfi_pkg::S_RD;
        end else if (ptr == q) begin
          g_next     = '0;
          ptr_next   = s;
          start_next = s;
          ret_next   = qfi_pkg::S_SCAN;
          state_next = qfi_pkg::S_RD;
        end else begin
          g_next     = '0;
          ptr_next   = s + 1'b1;
          ret_next   = qfi_pkg::S_RUNS;
          state_next = qfi_pkg::S_RD;
        end
      end

      // rd is slot ptr within the run
      qfi_pkg::S_SCAN: begin
        if (cmd == qfi_pkg::CMD_FIND) begin
          // g==0 marks the run head, later slots need cont
          if (g != '0 && !(rd.cont && g < CNT_W'(NSLOTS))) begin
            obuf_next   = mk(qfi_pkg::ST_MISS);
            ovalid_next = 1'b1;
            state_next  = qfi_pkg::S_IDLE;
          end else if (rd.tag == tag) begin
            tmp = rd;
            if (rd.hits != HIT_MAX) tmp.hits = rd.hits + 1'b1;
            we          = 1'b1;
            wdata       = tmp;
            obuf_next   = mk(qfi_pkg::ST_HIT);
            ovalid_next = 1'b1;
            state_next  = qfi_pkg::S_IDLE;
          end else begin
            s_next     = ptr + 1'b1;
            ptr_next   = ptr + 1'b1;
            g_next     = g + 1'b1;
            ret_next   = qfi_pkg::S_SCAN;
            state_next = qfi_pkg::S_RD;
          end
        end else begin
          // insert: g==0 marks the run head, later slots need cont
          if (!was_occ || (g != '0 && !(rd.cont && g < CNT_W'(NSLOTS)))) begin
            // place at ptr
            ne.cont = was_occ && (ptr != start);
            ne.shf  = (ptr != q);
            if (was_occ && ptr == start) begin
              // old head becomes continuation
              tmp          = rd;
              tmp.cont     = 1'b1;
              cur_next     = ne;
              cur_next.cont = 1'b0;
            end
            cur_next = ne;
            s_next   = ptr;
            g_next   = '0;
            ret_next = qfi_pkg::S_SHIFT;
            state_next = qfi_pkg::S_SHIFT;
          end else if (rd.tag == tag) begin
            obuf_next   = mk(qfi_pkg::ST_DUP);
            ovalid_next = 1'b1;
            state_next  = qfi_pkg::S_IDLE;
          end else if (rd.tag > tag) begin
            ne.cont  = (ptr != start);
            ne.shf   = (ptr != q);
            cur_next = ne;
            s_next   = ptr;
            g_next   = '0;
            state_next = qfi_pkg::S_SHIFT;
          end else begin
            ptr_next   = ptr + 1'b1;
            g_next     = g + 1'b1;
            ret_next   = qfi_pkg::S_SCAN;
            state_next = qfi_pkg::S_RD;
          end
        end
      end

      // rd is slot ptr; write cur, carry old entry forward
      qfi_pkg::S_SHIFT: begin
        tmp = rd;
        we  = 1'b1;
        wdata = cur;
        if (g == '0 && was_occ && ptr == start) begin
          tmp.cont = 1'b1;
        end
        if (rd.valid) begin
          tmp.shf = 1'b1;
          if (rd.occ) begin
            wdata.occ = 1'b1;
            tmp.occ   = 1'b0;
          end
        end
        cur_next = tmp;
        g_next   = g + 1'b1;
        if (!rd.valid || g >= CNT_W'(NSLOTS - 1)) begin
          cnt_next    = cnt + 1'b1;
          obuf_next   = mk(qfi_pkg::ST_INSERTED);
          ovalid_next = 1'b1;
          state_next  = qfi_pkg::S_IDLE;
        end else begin
          ptr_next   = ptr + 1'b1;
          ret_next   = qfi_pkg::S_SHIFT;
          state_next = qfi_pkg::S_RD;
        end
      end

      // rd is slot ptr; emit when the output buffer is free
      qfi_pkg::S_FLUSH: begin
        if (!ovalid || out_ready) begin
          if (rd.valid) begin
            found_next           = 1'b1;
            obuf_next.status     = qfi_pkg::ST_FLUSHED;
            obuf_next.entry_tag  = qfi_pkg::ETAG_W'(rd.tag);
            obuf_next.entry_hits = qfi_pkg::EHIT_W'(rd.hits);
            obuf_next.last       = (cnt == CNT_W'(1));
            cnt_next             = cnt - 1'b1;
            ovalid_next          = 1'b1;
          end
          if (ptr == SLOT_BITS'(NSLOTS - 1) || (rd.valid && cnt == CNT_W'(1))) begin
            if (!found && !rd.valid) begin
              obuf_next   = mk(qfi_pkg::ST_EMPTY);
              ovalid_next = 1'b1;
            end
            ptr_next   = '0;
            state_next = qfi_pkg::S_CLEAR;
          end else begin
            ptr_next   = ptr + 1'b1;
            ret_next   = qfi_pkg::S_FLUSH;
            state_next = qfi_pkg::S_RD;
          end
        end
      end

      // clearing pass, one slot a cycle
      qfi_pkg::S_CLEAR: begin
        we       = 1'b1;
        wdata    = '0;
        cnt_next = '0;
        ptr_next = ptr + 1'b1;
        if (ptr == SLOT_BITS'(NSLOTS - 1)) begin
          clr_done_next = 1'b1;
          state_next    = qfi_pkg::S_IDLE;
        end
      end

      default: state_next = qfi_pkg::S_IDLE;
    endcase
  end

endmodule
